### rtl/prt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants for the pointer reference-count table
// Table geometry, entry layout, result codes and the bucket hash.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int BUCKET_BITS = 12;
  localparam int WAYS        = 4;
  localparam int KEY_BITS    = 48;
  localparam int HASH_SHIFT  = 12;

  localparam int KEY_IN_W    = 48;
  localparam int COUNT_W     = 32;
  localparam int HID_W       = 8;
  localparam int STATUS_W    = 2;

  localparam int KEY_W       = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    REQ_INC = 1'b0,
    REQ_DEC = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_ZERO_KEY    = 2'd1,
    STATUS_NOT_TRACKED = 2'd2,
    STATUS_BUCKET_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [HID_W-1:0]   handler;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic                done;
    logic                found;
    logic [WAY_BITS-1:0] hit_way;
    logic                have_free;
    logic [WAY_BITS-1:0] free_way;
  } scan_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic                released;
    logic [HID_W-1:0]    release_handler;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic [BUCKET_BITS-1:0] hash_f(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = (k >> HASH_SHIFT) ^ k;
    return h[BUCKET_BITS-1:0];
  endfunction

endpackage

### rtl/prt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_if: request and response channels
// Valid/ready channels carrying one request or one response transaction.
// ----------------------------------------------------------------------------
interface prt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [prt_pkg::KEY_IN_W-1:0]  key;
  logic [prt_pkg::HID_W-1:0]     handler_id;

  modport source (output valid, req_type, key, handler_id, input ready);
  modport sink   (input valid, req_type, key, handler_id, output ready);
endinterface

interface prt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [prt_pkg::COUNT_W-1:0]   count;
  logic                          released;
  logic [prt_pkg::HID_W-1:0]     release_handler;
  logic [prt_pkg::STATUS_W-1:0]  status;

  modport source (output valid, count, released, release_handler, status, input ready);
  modport sink   (input valid, count, released, release_handler, status, output ready);
endinterface

### rtl/prt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/prt_way_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_way_scan: way-by-way key compare over one bucket row
// One shared key comparator visits one way per cycle and records the first
// matching valid way and the lowest free way.
// ----------------------------------------------------------------------------
module prt_way_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  prt_pkg::row_t            row_i,
  input  logic [prt_pkg::KEY_W-1:0] key_i,
  output prt_pkg::scan_t           res_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [prt_pkg::WAY_BITS-1:0] way_q, way_d;
  logic                         found_q, found_d;
  logic [prt_pkg::WAY_BITS-1:0] hit_q, hit_d;
  logic                         free_q, free_d;
  logic [prt_pkg::WAY_BITS-1:0] free_way_q, free_way_d;
  prt_pkg::entry_t              cur;
  logic                         key_eq;
  logic                         last_way;

  assign cur      = row_i[way_q];
  assign key_eq   = (cur.key == key_i);
  assign last_way = (way_q == prt_pkg::WAY_BITS'(prt_pkg::WAYS - 1));

  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    way_d      = way_q;
    found_d    = found_q;
    hit_d      = hit_q;
    free_d     = free_q;
    free_way_d = free_way_q;
    if (start_i) begin
      busy_d  = 1'b1;
      way_d   = '0;
      found_d = 1'b0;
      free_d  = 1'b0;
    end else if (busy_q) begin
      if (cur.valid) begin
        if (!found_q && key_eq) begin
          found_d = 1'b1;
          hit_d   = way_q;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_way_d = way_q;
      end
      if (last_way) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        way_d = way_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      way_q   <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      way_q   <= way_d;
      found_q <= found_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q      <= hit_d;
    free_way_q <= free_way_d;
  end

  assign res_o.done      = done_q;
  assign res_o.found     = found_q;
  assign res_o.hit_way   = hit_q;
  assign res_o.have_free = free_q;
  assign res_o.free_way  = free_way_q;

endmodule

### rtl/pointer_refcount_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_refcount_table_core: hashed reference-count table
// Tracks reference counts keyed by object address in a bucketed table.
//
// Channels: req_i takes one request transaction (req_type, key, handler_id);
// rsp_o returns exactly one response transaction per request (count,
// released, release_handler, status), in request order.
// Datapath: a request with a nonzero key passes through bucket read, way
// compare (one way compared per cycle in the shared comparator), count
// update through one adder, write-back and output load. A zero key skips
// the table and goes straight to the output load.
// Flow: one request at a time; req_i.ready is high only between requests,
// so a new request is not taken until the previous one has been through
// the way-serial compare loop and reached the output register.
// Reset: after rst_ni rises the table is swept one bucket per cycle to clear
// all NUM_BUCKETS (4096) buckets; req_i.ready stays low meanwhile.
// Stall: the response sits in an output register; a new request is taken
// while it waits, but that request's response holds until the slot frees.
// ----------------------------------------------------------------------------
module pointer_refcount_table_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  prt_req_if.sink   req_i,
  prt_rsp_if.source rsp_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e                           state_q, state_d;
  logic [prt_pkg::BUCKET_BITS-1:0]  clr_cnt_q, clr_cnt_d;
  logic [prt_pkg::BUCKET_BITS-1:0]  bucket_q, bucket_d;
  logic                             req_type_q, req_type_d;
  logic [prt_pkg::KEY_W-1:0]        key_q, key_d;
  logic [prt_pkg::HID_W-1:0]        hid_q, hid_d;
  prt_pkg::row_t                    row_q, row_d;
  prt_pkg::result_t                 res_q, res_d;
  prt_pkg::result_t                 out_q, out_d;
  logic                             out_valid_q, out_valid_d;

  logic [prt_pkg::KEY_W-1:0]        key_in;
  logic                             accept;
  logic                             out_free;
  logic                             ram_we;
  logic [prt_pkg::BUCKET_BITS-1:0]  ram_waddr;
  logic [prt_pkg::BUCKET_BITS-1:0]  ram_raddr;
  logic [prt_pkg::ROW_W-1:0]        ram_wdata;
  logic [prt_pkg::ROW_W-1:0]        ram_rdata;
  logic                             scan_start;
  prt_pkg::scan_t                   scan_res;
  prt_pkg::entry_t                  hit_ent;
  prt_pkg::entry_t                  upd_ent;
  logic [prt_pkg::WAY_BITS-1:0]     wr_way;
  prt_pkg::row_t                    wr_row;
  logic                             do_write;
  logic [prt_pkg::COUNT_W-1:0]      add_out;
  prt_pkg::result_t                 upd_res;

  assign key_in   = req_i.key[prt_pkg::KEY_W-1:0];
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);

  prt_ram #(
    .WIDTH (prt_pkg::ROW_W),
    .DEPTH (prt_pkg::NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign scan_start = (state_q == ST_READ);

  prt_way_scan u_way_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .row_i   (row_q),
    .key_i   (key_q),
    .res_o   (scan_res)
  );

  // shared count adder: +1 on increase, -1 on decrease
  assign hit_ent = row_q[scan_res.hit_way];
  assign add_out = hit_ent.count +
                   ((req_type_q == prt_pkg::REQ_DEC) ? prt_pkg::COUNT_MAX
                                                     : prt_pkg::COUNT_W'(1));
  assign wr_way  = scan_res.found ? scan_res.hit_way : scan_res.free_way;

  always_comb begin
    upd_ent                 = hit_ent;
    do_write                = 1'b0;
    upd_res.count           = '0;
    upd_res.released        = 1'b0;
    upd_res.release_handler = '0;
    upd_res.status          = prt_pkg::STATUS_OK;
    if (req_type_q == prt_pkg::REQ_INC) begin
      if (scan_res.found) begin
        do_write = 1'b1;
        if (hit_ent.count != prt_pkg::COUNT_MAX) begin
          upd_ent.count = add_out;
        end
        upd_res.count = upd_ent.count;
      end else if (scan_res.have_free) begin
        do_write        = 1'b1;
        upd_ent.valid   = 1'b1;
        upd_ent.key     = key_q;
        upd_ent.count   = prt_pkg::COUNT_W'(1);
        upd_ent.handler = hid_q;
        upd_res.count   = prt_pkg::COUNT_W'(1);
      end else begin
        upd_res.status = prt_pkg::STATUS_BUCKET_FULL;
      end
    end else begin
      if (scan_res.found) begin
        do_write      = 1'b1;
        upd_ent.count = add_out;
        if (add_out == '0) begin
          upd_ent.valid           = 1'b0;
          upd_res.released        = 1'b1;
          upd_res.release_handler = hit_ent.handler;
        end else begin
          upd_res.count = add_out;
        end
      end else begin
        upd_res.status = prt_pkg::STATUS_NOT_TRACKED;
      end
    end
  end

  always_comb begin
    wr_row         = row_q;
    wr_row[wr_way] = upd_ent;
  end

  assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && do_write);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : bucket_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wr_row;
  assign ram_raddr = (state_q == ST_IDLE) ? prt_pkg::hash_f(key_in) : bucket_q;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    bucket_d    = bucket_q;
    req_type_d  = req_type_q;
    key_d       = key_q;
    hid_d       = hid_q;
    row_d       = row_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == prt_pkg::BUCKET_BITS'(prt_pkg::NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_type_d = req_i.req_type;
          key_d      = key_in;
          hid_d      = req_i.handler_id;
          bucket_d   = prt_pkg::hash_f(key_in);
          if (key_in == '0) begin
            res_d.count           = '0;
            res_d.released        = 1'b0;
            res_d.release_handler = '0;
            res_d.status          = prt_pkg::STATUS_ZERO_KEY;
            state_d               = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        row_d   = ram_rdata;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        res_d   = upd_res;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bucket_q   <= bucket_d;
    req_type_q <= req_type_d;
    key_q      <= key_d;
    hid_q      <= hid_d;
    row_q      <= row_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.count           = out_q.count;
  assign rsp_o.released        = out_q.released;
  assign rsp_o.release_handler = out_q.release_handler;
  assign rsp_o.status          = out_q.status;

`ifndef SYNTH
  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !rsp_o.valid)
    else $error("response valid during table clear");

  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == ST_SCAN))
    else $error("way scan finished outside scan state");

  a_ram_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
    else $error("table write outside clear or update");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (rsp_o.valid && state_q == ST_IDLE))
    else $error("finished request did not reach the output register");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.released) |->
      (rsp_o.count == '0 && rsp_o.status == prt_pkg::STATUS_OK))
    else $error("release reported with nonzero count or error status");
`endif

endmodule
